// ----- hdl/fdtt_pkg.sv -----
`timescale 1ns / 1ps
// shared types, sizes and codes for the frame delay timer table
// no dependencies
package fdtt_pkg;

    localparam int TASK_SLOTS = 16;
    localparam int COUNT_BITS = 16;

    localparam int IVL_W  = 16;
    localparam int REP_W  = 9;
    localparam int TAG_W  = 8;
    localparam int PEND_W = 5;
    localparam int EV_W   = 2;
    localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
    localparam int WIDE_W = (COUNT_BITS > IVL_W) ? COUNT_BITS : IVL_W;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

    localparam logic       MODE_TICK  = 1'b0;
    localparam logic       MODE_SCHED = 1'b1;

    localparam logic [EV_W-1:0] EV_FIRED  = 2'd0;
    localparam logic [EV_W-1:0] EV_ACCEPT = 2'd1;
    localparam logic [EV_W-1:0] EV_FULL   = 2'd2;

    typedef struct packed {
        logic [COUNT_BITS-1:0] countdown;
        logic [COUNT_BITS-1:0] reload;
        logic [REP_W-1:0]      fires;
        logic [TAG_W-1:0]      tag;
    } slot_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_EMIT
    } state_t;

endpackage

// ----- hdl/fdtt_cell.sv -----
`timescale 1ns / 1ps
// one task slot of the shifting table
// depends on fdtt_pkg
module fdtt_cell
(
    input  logic               clk,
    input  fdtt_pkg::cell_ctl_t ctl,
    input  fdtt_pkg::slot_t    load_data,
    input  fdtt_pkg::slot_t    nbr,
    output fdtt_pkg::slot_t    slot
);
    import fdtt_pkg::*;

    slot_t slot_reg;
    slot_t slot_next;

    // a load wins over the shift from the neighbor toward the head
    always_comb
    begin
        if (ctl.load)
        begin
            slot_next = load_data;
        end
        else if (ctl.shift)
        begin
            slot_next = nbr;
        end
        else
        begin
            slot_next = slot_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

// ----- hdl/fdtt_head.sv -----
`timescale 1ns / 1ps
// countdown and fire-count update for the task leaving the head of the table
// depends on fdtt_pkg
module fdtt_head
(
    input  fdtt_pkg::slot_t head,
    output fdtt_pkg::slot_t upd,
    output logic            fire,
    output logic            keep
);
    import fdtt_pkg::*;

    logic [COUNT_BITS-1:0] cd;
    logic [REP_W-1:0]      fires_dec;
    logic                  forever_task;

    always_comb
    begin
        cd           = head.countdown - COUNT_BITS'(1);
        fire         = (cd == '0);
        forever_task = head.fires[REP_W-1];
        if (fire && !forever_task && (head.fires != '0))
        begin
            fires_dec = head.fires - REP_W'(1);
        end
        else
        begin
            fires_dec = head.fires;
        end
        // removed once its last fire is spent
        keep          = !(fire && (fires_dec == '0));
        upd.countdown = fire ? head.reload : cd;
        upd.reload    = head.reload;
        upd.fires     = fires_dec;
        upd.tag       = head.tag;
    end

endmodule

// ----- hdl/frame_delay_timer_table_top.sv -----
`timescale 1ns / 1ps
// frame delay timer table: a row of task cells that shifts toward the head
// depends on fdtt_pkg, fdtt_cell, fdtt_head
//
// schedule word: result word registered on acceptance, valid in the cycle after
// tick word: the row is scanned once per held task (head task leaves, survivor
//   rejoins at the tail), then one fired word per cycle while the output is free
// a tick that finds no task due, or an empty table, gives no word
// reset clears the task count and the control state; slot contents stay undefined
module frame_delay_timer_table_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // interval [15:0], repeat_count [24:16], task_tag [32:25], zero pad [39:33]
    input  logic [fdtt_pkg::S_DATA_W-1:0] s_axis_tdata,
    // mode [0]
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // fired_tag [7:0], tasks_pending [12:8], zero pad [15:13]
    output logic [fdtt_pkg::M_DATA_W-1:0] m_axis_tdata,
    // event_res [1:0]
    output logic [fdtt_pkg::EV_W-1:0]     m_axis_tuser,
    // last
    output logic                          m_axis_tlast
);
    import fdtt_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] step_reg;
    logic [CNT_W-1:0] step_next;
    logic [CNT_W-1:0] nf_reg;
    logic [CNT_W-1:0] nf_next;

    logic [TAG_W-1:0] fq_reg [TASK_SLOTS];

    logic             m_valid_reg;
    logic [EV_W-1:0]  m_ev_reg;
    logic [TAG_W-1:0] m_tag_reg;
    logic [PEND_W-1:0] m_pend_reg;
    logic             m_last_reg;

    // input word fields
    logic [IVL_W-1:0] in_ivl;
    logic [REP_W-1:0] in_rep;
    logic [TAG_W-1:0] in_tag;
    logic             in_mode;

    logic             s_fire;
    logic             out_free;
    logic             full;
    logic             sched_ok;
    logic             pop;
    logic             push;
    logic             emit_load;
    logic [CNT_W-1:0] wpos;

    logic [WIDE_W-1:0] ivl_wide;
    slot_t            sched_data;
    slot_t            push_data;
    slot_t            head_upd;
    logic             head_fire;
    logic             head_keep;

    slot_t            cells [TASK_SLOTS];

    assign in_ivl  = s_axis_tdata[15:0];
    assign in_rep  = s_axis_tdata[24:16];
    assign in_tag  = s_axis_tdata[32:25];
    assign in_mode = s_axis_tuser;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign full     = (count_reg >= CNT_W'(TASK_SLOTS));
    assign sched_ok = s_fire && (in_mode == MODE_SCHED) && !full;

    // new task: zero interval counts as one, too wide saturates, zero repeats fire once
    always_comb
    begin
        ivl_wide = WIDE_W'(in_ivl);
        if (ivl_wide == '0)
        begin
            ivl_wide = WIDE_W'(1);
        end
        if (ivl_wide > WIDE_W'({COUNT_BITS{1'b1}}))
        begin
            ivl_wide = WIDE_W'({COUNT_BITS{1'b1}});
        end
        sched_data.countdown = ivl_wide[COUNT_BITS-1:0];
        sched_data.reload    = ivl_wide[COUNT_BITS-1:0];
        sched_data.fires     = (in_rep == '0) ? REP_W'(1) : in_rep;
        sched_data.tag       = in_tag;
    end

    fdtt_head u_head
    (
        .head (cells[0]),
        .upd  (head_upd),
        .fire (head_fire),
        .keep (head_keep)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && (in_mode == MODE_TICK) && (count_reg != '0))
                begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK:
            begin
                if (step_reg == CNT_W'(1))
                begin
                    state_next = ((nf_reg != '0) || head_fire) ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free && (nf_reg == CNT_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs of the sequencer
    always_comb
    begin
        s_axis_tready = 1'b0;
        pop           = 1'b0;
        push          = 1'b0;
        emit_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = out_free;
                push          = sched_ok;
            end
            ST_TICK:
            begin
                pop  = 1'b1;
                push = head_keep;
            end
            ST_EMIT:
            begin
                emit_load = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // survivor rejoins at the tail after the shift, a new task at the tail as is
    assign wpos      = pop ? (count_reg - CNT_W'(1)) : count_reg;
    assign push_data = pop ? head_upd : sched_data;

    // row of task cells
    genvar gi;
    generate
        for (gi = 0; gi < TASK_SLOTS; gi++)
        begin : g_cell
            cell_ctl_t ctl;
            slot_t     nbr;

            assign ctl = '{shift: pop, load: (push && (wpos == CNT_W'(gi)))};

            if (gi == TASK_SLOTS - 1)
            begin : g_tail
                assign nbr = cells[gi];
            end
            else
            begin : g_mid
                assign nbr = cells[gi + 1];
            end

            fdtt_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl),
                .load_data (push_data),
                .nbr       (nbr),
                .slot      (cells[gi])
            );
        end
    endgenerate

    // fired tags wait here until the scan is done and the final count is known
    generate
        for (gi = 0; gi < TASK_SLOTS; gi++)
        begin : g_fq
            always_ff @(posedge clk)
            begin
                if ((state_reg == ST_TICK) && head_fire && (nf_reg == CNT_W'(gi)))
                begin
                    fq_reg[gi] <= head_upd.tag;
                end
                else if (emit_load)
                begin
                    if (gi == TASK_SLOTS - 1)
                    begin
                        fq_reg[gi] <= fq_reg[gi];
                    end
                    else
                    begin
                        fq_reg[gi] <= fq_reg[(gi + 1) % TASK_SLOTS];
                    end
                end
            end
        end
    endgenerate

    // counters
    always_comb
    begin
        count_next = count_reg;
        step_next  = step_reg;
        nf_next    = nf_reg;
        if (sched_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (s_fire && (in_mode == MODE_TICK))
        begin
            step_next = count_reg;
        end
        if (state_reg == ST_TICK)
        begin
            count_next = count_reg - CNT_W'(1) + CNT_W'(head_keep);
            step_next  = step_reg - CNT_W'(1);
            nf_next    = nf_reg + CNT_W'(head_fire);
        end
        if (emit_load)
        begin
            nf_next = nf_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            step_reg    <= '0;
            nf_reg      <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            nf_reg    <= nf_next;
            if ((s_fire && (in_mode == MODE_SCHED)) || emit_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (s_fire && (in_mode == MODE_SCHED))
        begin
            m_ev_reg   <= full ? EV_FULL : EV_ACCEPT;
            m_tag_reg  <= in_tag;
            m_pend_reg <= full ? PEND_W'(count_reg) : PEND_W'(count_reg + CNT_W'(1));
            m_last_reg <= 1'b1;
        end
        else if (emit_load)
        begin
            m_ev_reg   <= EV_FIRED;
            m_tag_reg  <= fq_reg[0];
            m_pend_reg <= PEND_W'(count_reg);
            m_last_reg <= (nf_reg == CNT_W'(1));
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_ev_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = M_DATA_W'({m_pend_reg, m_tag_reg});

    // the task count never goes past the row length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TASK_SLOTS))
        else $error("task count beyond table size");

    // a scan step always has a task at the head
    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK) |-> ((step_reg != '0) && (count_reg != '0)))
        else $error("scan step with no task");

    // emitting only while fired tags are queued
    a_emit_nf: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (nf_reg != '0))
        else $error("emit with empty fired queue");

    // the fired queue is empty whenever new words can be taken
    a_idle_nf: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (nf_reg == '0))
        else $error("fired tags left over in idle");

    // each emit load puts a fired word on the output
    a_emit_word: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load) |=> (m_axis_tvalid && (m_axis_tuser == EV_FIRED)))
        else $error("fired word not presented");

endmodule
